// ----- hw/rtl/hss_pkg.sv -----
// Shared constants and the sine table generator for the harmonic sine synthesizer.
package hss_pkg;

  localparam int unsigned STEP_W = 32;

  // pi/2 in unsigned Q2.30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // divide by five: (n * DIV_MULT) >> DIV_SHIFT is exact for n < 2^30
  localparam int unsigned DIV_SHIFT = 32;
  localparam int unsigned DIV_MULT_W = 30;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = 30'd858993460;
  localparam int unsigned ROUND_BIAS = 2;

  // Unsigned quotient by shift and subtract, elaboration only.
  function automatic longint unsigned udiv_f(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | {63'd0, num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine entry, evaluated at elaboration only.
  function automatic longint unsigned quarter_sine_f(int unsigned idx, int unsigned addr_bits,
                                                     int unsigned sample_bits);
    longint unsigned x;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned s;
    longint unsigned amp;
    longint unsigned dv;
    bit minus;
    x     = (HALF_PI_Q30 * longint'(idx)) >> (addr_bits - 2);
    term  = x;
    pos   = x;
    neg   = 0;
    amp   = (64'd1 << (sample_bits - 1)) - 64'd1;
    minus = 1'b1;
    for (int n = 1; n < 17; n += 2) begin
      dv   = longint'((n + 1) * (n + 2));
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = udiv_f(term, dv);
      if (minus) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
      minus = !minus;
    end
    s = (pos > neg) ? pos - neg : 64'd0;
    if (s > (64'd1 << 30)) begin
      s = 64'd1 << 30;
    end
    return (s * amp + (64'd1 << 29)) >> 30;
  endfunction

endpackage

// ----- hw/rtl/hss_front.sv -----
// Front end: takes phase steps and advances the harmonic phase accumulators.
module hss_front #(
  parameter int PHASE_BITS     = 32,
  parameter int SINE_ADDR_BITS = 10,
  parameter int HARMONICS      = 4
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           in_valid_i,
  output logic                                           in_ready_o,
  input  logic [hss_pkg::STEP_W-1:0]                     in_step_i,
  output logic                                           push_valid_o,
  input  logic                                           push_ready_i,
  output logic [HARMONICS-1:0][SINE_ADDR_BITS-1:0]       push_addr_o
);
  import hss_pkg::*;

  logic [PHASE_BITS-1:0] step_ext;
  logic [PHASE_BITS-1:0] phase_q [HARMONICS];
  logic [PHASE_BITS-1:0] phase_d [HARMONICS];
  logic                  take;

  if (PHASE_BITS <= STEP_W) begin : g_step_trunc
    assign step_ext = in_step_i[PHASE_BITS-1:0];
  end else begin : g_step_ext
    assign step_ext = {{(PHASE_BITS - STEP_W){1'b0}}, in_step_i};
  end

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign take         = in_valid_i && push_ready_i;

  for (genvar k = 0; k < HARMONICS; k++) begin : g_acc
    // harmonic k+1 advances by (k+1) times the fundamental step
    assign phase_d[k]     = phase_q[k] + PHASE_BITS'(step_ext * PHASE_BITS'(k + 1));
    assign push_addr_o[k] = phase_d[k][PHASE_BITS-1 -: SINE_ADDR_BITS];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        phase_q[k] <= '0;
      end else if (take) begin
        phase_q[k] <= phase_d[k];
      end
    end
  end

endmodule

// ----- hw/rtl/hss_queue.sv -----
// Two-entry queue of table addresses between the front and back ends.
module hss_queue #(
  parameter int DATA_W = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);
  import hss_pkg::*;

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        count_q;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- hw/rtl/hss_back.sv -----
// Back end: sine lookup, harmonic sum, divide by five and saturation.
module hss_back #(
  parameter int SINE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS    = 16,
  parameter int HARMONICS      = 4
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     pop_valid_i,
  output logic                                     pop_ready_o,
  input  logic [HARMONICS-1:0][SINE_ADDR_BITS-1:0] pop_addr_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]            out_sample_o
);
  import hss_pkg::*;

  localparam int QSIZE  = 2 ** (SINE_ADDR_BITS - 2);
  localparam int IDX_W  = SINE_ADDR_BITS - 2;
  localparam int RADR_W = SINE_ADDR_BITS - 1;
  localparam int AMP_W  = SAMPLE_BITS - 1;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(HARMONICS) + 1;
  localparam int PROD_W = SUM_W + DIV_MULT_W;
  localparam int QUOT_W = PROD_W - DIV_SHIFT;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  // quarter-wave table, constant
  logic [AMP_W-1:0] rom_w [QSIZE+1];
  for (genvar i = 0; i <= QSIZE; i++) begin : g_rom
    localparam longint unsigned ENTRY = quarter_sine_f(i, SINE_ADDR_BITS, SAMPLE_BITS);
    assign rom_w[i] = ENTRY[AMP_W-1:0];
  end

  logic                      adv;
  logic                      v1_q, v2_q, v3_q, v4_q;
  logic [AMP_W-1:0]          mag1_q [HARMONICS];
  logic [HARMONICS-1:0]      neg1_q;
  logic signed [SUM_W-1:0]   sum2_d, sum2_q;
  logic [SUM_W-1:0]          abs2;
  logic [PROD_W-1:0]         prod3_q;
  logic                      neg3_q;
  logic [QUOT_W-1:0]         quot3;
  logic signed [SUM_W-1:0]   q3;
  logic signed [SUM_W-1:0]   sat3;
  logic signed [SAMPLE_BITS-1:0] out_q;

  // whole pipeline moves when the output register is free
  assign adv          = !v4_q || out_ready_i;
  assign pop_ready_o  = adv;
  assign out_valid_o  = v4_q;
  assign out_sample_o = out_q;

  for (genvar k = 0; k < HARMONICS; k++) begin : g_lane
    logic [1:0]        quad;
    logic [IDX_W-1:0]  idx;
    logic [RADR_W-1:0] radr;
    assign quad = pop_addr_i[k][SINE_ADDR_BITS-1 -: 2];
    assign idx  = pop_addr_i[k][IDX_W-1:0];
    // odd quadrants read the table mirrored
    assign radr = quad[0] ? RADR_W'(QSIZE) - RADR_W'(idx) : RADR_W'(idx);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        mag1_q[k] <= rom_w[radr];
        neg1_q[k] <= quad[1];
      end
    end
  end

  always_comb begin
    sum2_d = '0;
    for (int k = 0; k < HARMONICS; k++) begin
      if (neg1_q[k]) begin
        sum2_d = sum2_d - $signed(SUM_W'(mag1_q[k]));
      end else begin
        sum2_d = sum2_d + $signed(SUM_W'(mag1_q[k]));
      end
    end
  end

  assign abs2  = sum2_q[SUM_W-1] ? SUM_W'(-sum2_q) : SUM_W'(sum2_q);
  assign quot3 = prod3_q[PROD_W-1 -: QUOT_W];
  assign q3    = neg3_q ? -$signed(SUM_W'(quot3)) : $signed(SUM_W'(quot3));

  always_comb begin
    sat3 = q3;
    if (q3 > SAT_HI) begin
      sat3 = SAT_HI;
    end else if (q3 < SAT_LO) begin
      sat3 = SAT_LO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum2_q  <= sum2_d;
      neg3_q  <= sum2_q[SUM_W-1];
      prod3_q <= PROD_W'(abs2 + SUM_W'(ROUND_BIAS)) * PROD_W'(DIV_MULT);
      out_q   <= sat3[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pop_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

endmodule

// ----- hw/rtl/harmonic_sine_synthesizer.sv -----
// Top level of the harmonic sine synthesizer.
//
// Input stream (s_t*): one item per sample tick, tdata carries the 32-bit
// fundamental phase step (2^32 is one turn). Output stream (m_t*): one signed
// sample per input item, the sum of the first HARMONICS harmonic sines divided
// by five, rounded to nearest and saturated.
// The front end advances HARMONICS phase accumulators (harmonic k by k times
// the step) and queues the table addresses in a two-entry queue. The back end
// is a four-stage pipeline: table read, signed sum, reciprocal multiply by one
// fifth, negate and saturate into the output register.
// An accepted step passes through a queue entry and then the four back-end
// registers before m_tvalid rises. Throughput: one item per cycle while the
// output is not stalled, as each accumulator updates once per accepted item.
// When m_tready is low with a sample waiting the back pipeline holds; s_tready
// drops once the two-entry queue is full. Reset clears all phases to zero and
// empties the queue and pipeline; the sine table is constant and needs no fill.
module harmonic_sine_synthesizer #(
  parameter int PHASE_BITS     = 32,
  parameter int SINE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS    = 16,
  parameter int HARMONICS      = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [hss_pkg::STEP_W-1:0]            s_tdata,  // [31:0] phase_step
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_tdata  // sample, then zero pad
);
  import hss_pkg::*;

  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int QD_W  = HARMONICS * SINE_ADDR_BITS;

  logic                                     push_valid;
  logic                                     push_ready;
  logic [HARMONICS-1:0][SINE_ADDR_BITS-1:0] push_addr;
  logic                                     pop_valid;
  logic                                     pop_ready;
  logic [QD_W-1:0]                          pop_data;
  logic signed [SAMPLE_BITS-1:0]            sample;

  hss_front #(
    .PHASE_BITS    (PHASE_BITS),
    .SINE_ADDR_BITS(SINE_ADDR_BITS),
    .HARMONICS     (HARMONICS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .in_step_i   (s_tdata),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_addr_o (push_addr)
  );

  hss_queue #(
    .DATA_W(QD_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_addr),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  hss_back #(
    .SINE_ADDR_BITS(SINE_ADDR_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .HARMONICS     (HARMONICS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_addr_i  (pop_data),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_sample_o(sample)
  );

  assign m_tdata = OUT_W'(unsigned'(sample));

endmodule
